FILE: rtl/core/decimal_micron_to_dbu_defines.svh
// Assertion macros for the decimal micron to database unit converter.
`ifndef DECIMAL_MICRON_TO_DBU_DEFINES_SVH
`define DECIMAL_MICRON_TO_DBU_DEFINES_SVH
`ifndef SYNTH
// Checks that a condition implies another in the same cycle.
`define DMD_CHK_NOW(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("%m: same-cycle check failed");
// Checks that a condition implies another in the next cycle.
`define DMD_CHK_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("%m: next-cycle check failed");
`else
`define DMD_CHK_NOW(lbl, pre, post)
`define DMD_CHK_NEXT(lbl, pre, post)
`endif
`endif

FILE: rtl/core/dmd_pkg.sv
// Package with constants, types and the power-of-ten table of the converter.
package dmd_pkg;

  localparam int UPM_W = 20;
  localparam logic [UPM_W-1:0] UPM_RESET = 20'd1000;
  localparam int DEF_MAX_FRAC_DIGITS = 7;

  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_POINT = 8'h2E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // Position inside the current token.
  typedef enum logic [1:0] {
    PH_START  = 2'd0,
    PH_INT    = 2'd1,
    PH_FRAC   = 2'd2,
    PH_IGNORE = 2'd3
  } phase_t;

  // Sequencer states, one-hot.
  typedef enum logic [4:0] {
    ST_IDLE     = 5'b00001,
    ST_MUL_INT  = 5'b00010,
    ST_MUL_FRAC = 5'b00100,
    ST_DIV      = 5'b01000,
    ST_FINISH   = 5'b10000
  } state_t;

  // Ten raised to a digit count.
  function automatic logic [63:0] pow10(input logic [3:0] n);
    logic [63:0] v;
    case (n)
      4'd0: v = 64'd1;
      4'd1: v = 64'd10;
      4'd2: v = 64'd100;
      4'd3: v = 64'd1000;
      4'd4: v = 64'd10000;
      4'd5: v = 64'd100000;
      4'd6: v = 64'd1000000;
      4'd7: v = 64'd10000000;
      4'd8: v = 64'd100000000;
      default: v = 64'd1000000000;
    endcase
    return v;
  endfunction

endpackage

FILE: rtl/core/decimal_micron_to_dbu.sv
// Decimal micron token to database unit converter with rounding and saturation.
//
// Characters of one decimal token enter on the in_ channel, one per beat, the
// final one flagged by in_last_char. A beat without the flag is absorbed and
// the block stays ready. The final beat starts the sequencer: the shared
// multiplier scales the integer part and then the fraction part, then a
// restoring divider removes the fraction scale one quotient bit per cycle,
// and a final step adds, signs and saturates. The divider is skipped when the
// token has no fraction digits. in_ready stays low until the result is loaded
// into the output register.
// A result waits in the output register while out_ready is low. A finished
// token holds its final step until the register is free, and in_ready stays
// low meanwhile. The cfg_ port writes units per micron at once.
// Reset clears the token state, sets units per micron to 1000 and drops
// out_valid.
module decimal_micron_to_dbu
  import dmd_pkg::*;
#(
  parameter int MAX_FRAC_DIGITS = DEF_MAX_FRAC_DIGITS
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic [UPM_W-1:0]   cfg_wr_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         in_char_code,
  input  logic               in_last_char,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_dbu_value
);

  `include "decimal_micron_to_dbu_defines.svh"

  localparam int FRAC_W = $clog2(10**MAX_FRAC_DIGITS);
  localparam int FD_W   = $clog2(MAX_FRAC_DIGITS + 1);
  localparam int SC_W   = FRAC_W + 1;
  localparam int DIV_W  = FRAC_W + UPM_W + 1;
  localparam int CNT_W  = $clog2(DIV_W);
  localparam int PROD_W = 32 + UPM_W;
  localparam int MAG_W  = PROD_W + 1;
  localparam int QK_W   = UPM_W + 1;

  logic [UPM_W-1:0]  upm_r;
  state_t            state_r, state_nxt;
  phase_t            phase_r;
  logic              neg_r;
  logic [31:0]       int_r;
  logic [FRAC_W-1:0] frac_r;
  logic [FD_W-1:0]   fdig_r;
  logic [PROD_W-1:0] mag_r;
  logic [SC_W-1:0]   rem_r;
  logic [DIV_W-1:0]  quo_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              out_valid_r;
  logic [31:0]       out_data_r;

  // Character classification and accumulator updates.
  logic              chr_digit;
  logic [3:0]        dval;
  logic [35:0]       int_ext;
  logic [FRAC_W+3:0] frac_ext;
  logic              take;

  assign chr_digit = (in_char_code >= CH_ZERO) && (in_char_code <= CH_NINE);
  assign dval     = chr_digit ? 4'(in_char_code - CH_ZERO) : 4'd0;
  assign int_ext  = ({4'd0, int_r} << 3) + ({4'd0, int_r} << 1) + 36'(dval);
  assign frac_ext = ({4'd0, frac_r} << 3) + ({4'd0, frac_r} << 1) + (FRAC_W+4)'(dval);
  assign take     = in_valid && in_ready;

  // Shared multiplier: integer part first, then fraction part.
  logic [31:0]       mul_a;
  logic [PROD_W-1:0] prod;
  assign mul_a = (state_r == ST_MUL_INT) ? int_r : 32'(frac_r);
  assign prod  = PROD_W'(mul_a) * PROD_W'(upm_r);

  // Divider step and scale.
  logic [SC_W-1:0] sc;
  logic [SC_W:0]   trial;
  logic            qbit;
  assign sc    = SC_W'(pow10(4'(fdig_r)));
  assign trial = {rem_r, quo_r[DIV_W-1]};
  assign qbit  = trial >= {1'b0, sc};

  // Final add, sign and saturation.
  logic [MAG_W-1:0] mag_sum;
  logic [31:0]      final_val;
  assign mag_sum = {1'b0, mag_r} + MAG_W'(quo_r[QK_W-1:0]);
  always_comb begin
    if (neg_r) begin
      if (mag_sum >= MAG_W'(33'h80000000)) begin
        final_val = 32'h80000000;
      end else begin
        final_val = 32'd0 - mag_sum[31:0];
      end
    end else begin
      if (mag_sum > MAG_W'(32'h7FFFFFFF)) begin
        final_val = 32'h7FFFFFFF;
      end else begin
        final_val = mag_sum[31:0];
      end
    end
  end

  logic out_free;
  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_dbu_value = out_data_r;

  // Sequencer next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (take && in_last_char) state_nxt = ST_MUL_INT;
      end
      ST_MUL_INT: begin
        state_nxt = ST_MUL_FRAC;
      end
      ST_MUL_FRAC: begin
        state_nxt = (fdig_r == '0) ? ST_FINISH : ST_DIV;
      end
      ST_DIV: begin
        if (cnt_r == '0) state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Configuration register and sequencer state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upm_r   <= UPM_RESET;
      state_r <= ST_IDLE;
    end else begin
      if (cfg_wr_en) upm_r <= cfg_wr_data;
      state_r <= state_nxt;
    end
  end

  // Token state: updated per character, cleared once the result is loaded.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_START;
      neg_r   <= 1'b0;
      int_r   <= '0;
      frac_r  <= '0;
      fdig_r  <= '0;
    end else if (state_r == ST_FINISH && out_free) begin
      phase_r <= PH_START;
      neg_r   <= 1'b0;
      int_r   <= '0;
      frac_r  <= '0;
      fdig_r  <= '0;
    end else if (take) begin
      case (phase_r)
        PH_START, PH_INT: begin
          if (phase_r == PH_START &&
              (in_char_code == CH_MINUS || in_char_code == CH_PLUS)) begin
            neg_r   <= (in_char_code == CH_MINUS);
            phase_r <= PH_INT;
          end else if (chr_digit) begin
            int_r   <= (int_ext[35:32] != 4'd0) ? 32'hFFFFFFFF : int_ext[31:0];
            phase_r <= PH_INT;
          end else if (in_char_code == CH_POINT) begin
            phase_r <= PH_FRAC;
          end else begin
            phase_r <= PH_IGNORE;
          end
        end
        PH_FRAC: begin
          if (chr_digit && fdig_r < FD_W'(MAX_FRAC_DIGITS)) begin
            frac_r <= frac_ext[FRAC_W-1:0];
            fdig_r <= fdig_r + FD_W'(1);
            if (fdig_r + FD_W'(1) >= FD_W'(MAX_FRAC_DIGITS)) phase_r <= PH_IGNORE;
          end else begin
            phase_r <= PH_IGNORE;
          end
        end
        default: phase_r <= phase_r;
      endcase
    end
  end

  // Datapath: products, divider shift register and step count.
  always_ff @(posedge clk) begin
    case (state_r)
      ST_MUL_INT: begin
        mag_r <= prod;
      end
      ST_MUL_FRAC: begin
        rem_r <= '0;
        cnt_r <= CNT_W'(DIV_W - 1);
        if (fdig_r == '0) begin
          quo_r <= '0;
        end else begin
          quo_r <= DIV_W'(prod[FRAC_W+UPM_W-1:0]) + DIV_W'(sc >> 1);
        end
      end
      ST_DIV: begin
        rem_r <= qbit ? SC_W'(trial - {1'b0, sc}) : trial[SC_W-1:0];
        quo_r <= {quo_r[DIV_W-2:0], qbit};
        cnt_r <= cnt_r - CNT_W'(1);
      end
      default: begin
        mag_r <= mag_r;
      end
    endcase
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == ST_FINISH && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_FINISH && out_free) out_data_r <= final_val;
  end

  `DMD_CHK_NEXT(a_last_starts_mul, take && in_last_char, state_r == ST_MUL_INT)
  `DMD_CHK_NOW(a_rem_below_scale, state_r == ST_DIV, rem_r < sc)
  `DMD_CHK_NEXT(a_finish_loads_out, state_r == ST_FINISH && out_free, out_valid_r)

endmodule
